>>> rtl/core/ic5_pkg.sv
package ic5_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int NROWS      = 5;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SLOT_W     = 3;
    localparam int ADDR_W     = SLOT_W + COL_W;

    // register indexes
    localparam logic [1:0] REG_FILTER = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // kernel codes
    localparam logic [2:0] K_IDENT  = 3'd0;
    localparam logic [2:0] K_EDGE1  = 3'd1;
    localparam logic [2:0] K_EDGE2  = 3'd2;
    localparam logic [2:0] K_EDGE3  = 3'd3;
    localparam logic [2:0] K_SHARP  = 3'd4;
    localparam logic [2:0] K_BOX    = 3'd5;
    localparam logic [2:0] K_GAUSS3 = 3'd6;
    localparam logic [2:0] K_GAUSS5 = 3'd7;

    typedef logic [23:0] pix_t;

    // row slot: remainder by five through a reciprocal multiply, exact below 2^14
    function automatic logic [SLOT_W-1:0] mod5(input logic [ROW_W:0] x);
        logic [ROW_W+13:0] p;
        logic [ROW_W:0] q;
        logic [ROW_W:0] r;
        begin
            p = (ROW_W+14)'(x) * (ROW_W+14)'(3277);
            q = (ROW_W+1)'(p >> 14);
            r = x - (ROW_W+1)'(q * (ROW_W+1)'(5));
            return SLOT_W'(r);
        end
    endfunction

    // coefficient for kernel f at flipped tap (i,j), i,j in 0..4
    function automatic logic signed [6:0] kcoef(input logic [2:0] f,
                                                input logic [2:0] i,
                                                input logic [2:0] j);
        logic signed [6:0] k;
        logic in3;
        logic ctr;
        logic crs;
        logic [2:0] di;
        logic [2:0] dj;
        logic signed [6:0] gi;
        logic signed [6:0] gj;
        begin
            in3 = (i >= 3'd1) && (i <= 3'd3) && (j >= 3'd1) && (j <= 3'd3);
            ctr = (i == 3'd2) && (j == 3'd2);
            crs = in3 && !ctr && ((i == 3'd2) || (j == 3'd2));
            di  = (i > 3'd2) ? 3'(i - 3'd2) : 3'(3'd2 - i);
            dj  = (j > 3'd2) ? 3'(j - 3'd2) : 3'(3'd2 - j);
            gi  = (di == 3'd0) ? 7'sd6 : ((di == 3'd1) ? 7'sd4 : 7'sd1);
            gj  = (dj == 3'd0) ? 7'sd6 : ((dj == 3'd1) ? 7'sd4 : 7'sd1);
            k = 7'sd0;
            unique case (f)
                K_IDENT:  k = ctr ? 7'sd1 : 7'sd0;
                K_EDGE1: begin
                    if (in3 && !crs && !ctr)
                        k = (i == j) ? 7'sd1 : -7'sd1;
                end
                K_EDGE2:  k = ctr ? -7'sd4 : (crs ? 7'sd1 : 7'sd0);
                K_EDGE3:  k = ctr ? 7'sd8 : (in3 ? -7'sd1 : 7'sd0);
                K_SHARP:  k = ctr ? 7'sd5 : (crs ? -7'sd1 : 7'sd0);
                K_BOX:    k = in3 ? 7'sd1 : 7'sd0;
                K_GAUSS3: k = ctr ? 7'sd4 : (crs ? 7'sd2 : (in3 ? 7'sd1 : 7'sd0));
                K_GAUSS5: k = 7'(gi * gj);
                default:  k = 7'sd0;
            endcase
            return k;
        end
    endfunction

endpackage

>>> rtl/core/image_conv5x5_filter_core.sv
// channel  | handshake           | payload
// s_ in    | s_valid / s_ready   | s_mode, s_red_in, s_green_in, s_blue_in
// m_ out   | m_valid / m_ready   | m_red_out .. m_blue_out, m_run_last, m_frame_end
// cfg      | cfg_we              | cfg_index, cfg_data
// each result runs through a window check, 25 taps read one per cycle, a step
// to finish the sums and a step to scale into the output holding register; an
// item gives up to three results. a result is offered at the next window check
// aresetn clears counters, configuration, the sequencer, m_valid and m_run_last;
// line memory, sums and result data are not cleared. a stalled output holds the
// sequencer until the result is taken.
module image_conv5x5_filter_core
    import ic5_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_red_in,
    input  logic [7:0]  s_green_in,
    input  logic [7:0]  s_blue_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red_out,
    output logic [7:0]  m_green_out,
    output logic [7:0]  m_blue_out,
    output logic        m_run_last,
    output logic        m_frame_end,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CHK  = 3'd1;
    localparam logic [2:0] ST_TAP  = 3'd2;
    localparam logic [2:0] ST_LAST = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  fsel_reg;
    logic [10:0] wreg_reg;
    logic [12:0] hreg_reg;
    logic [COL_W-1:0] in_col_reg, out_col_reg;
    logic [ROW_W:0]   in_row_reg, out_row_reg;
    logic        flush_reg;
    logic [1:0]  nres_reg;
    logic [2:0]  ti_reg, tj_reg;
    logic [2:0]  pi_reg, pj_reg;
    logic        pv_reg;
    logic        pend_reg;
    logic signed [17:0] acc_reg [3];
    logic [7:0]  res_reg [3];
    logic        fe_reg;

    pix_t mem [NROWS * MAX_WIDTH];
    pix_t rd_reg;

    // effective geometry
    logic [COL_W:0] w_eff;
    logic [ROW_W:0] h_eff;
    always_comb begin
        if (wreg_reg == 11'd0) w_eff = (COL_W+1)'(1);
        else if (wreg_reg > 11'(MAX_WIDTH)) w_eff = (COL_W+1)'(MAX_WIDTH);
        else w_eff = (COL_W+1)'(wreg_reg);
        if (hreg_reg == 13'd0) h_eff = (ROW_W+1)'(1);
        else if (hreg_reg > 13'(MAX_HEIGHT)) h_eff = (ROW_W+1)'(MAX_HEIGHT);
        else h_eff = (ROW_W+1)'(hreg_reg);
    end

    // readiness of the next result window
    logic [ROW_W:0] ra;
    logic [COL_W:0] cb;
    logic rdy, more;
    always_comb begin
        ra = out_row_reg + (ROW_W+1)'(2);
        if (ra > h_eff - 1'b1) ra = h_eff - 1'b1;
        cb = {1'b0, out_col_reg} + (COL_W+1)'(2);
        if (cb > w_eff - 1'b1) cb = w_eff - 1'b1;
        rdy = (ra < in_row_reg) ||
              (ra == in_row_reg && cb < {1'b0, in_col_reg});
        if (flush_reg) more = (nres_reg == 2'd0) && (out_row_reg < h_eff) && rdy;
        else more = (nres_reg != 2'd3) &&
                    (out_row_reg + (ROW_W+1)'(2) < h_eff) && rdy;
    end

    // tap address with border replication
    logic signed [ROW_W+2:0] ta;
    logic signed [COL_W+2:0] tb;
    logic [ROW_W:0] ta_c;
    logic [COL_W-1:0] tb_c;
    logic [SLOT_W-1:0] slot;
    always_comb begin
        ta = $signed({2'b00, out_row_reg}) + $signed((ROW_W+3)'(ti_reg))
             - (ROW_W+3)'(2);
        tb = $signed({2'b00, out_col_reg}) + $signed((COL_W+3)'(tj_reg))
             - (COL_W+3)'(2);
        if (ta < 0) ta_c = '0;
        else if (ta > $signed({2'b00, h_eff}) - 1) ta_c = h_eff - 1'b1;
        else ta_c = ta[ROW_W:0];
        if (tb < 0) tb_c = '0;
        else if (tb > $signed({2'b00, w_eff}) - 1) tb_c = COL_W'(w_eff - 1'b1);
        else tb_c = tb[COL_W-1:0];
        slot = mod5(ta_c);
    end

    logic accept_in, store_px, out_fire;
    assign s_ready  = (state_reg == ST_IDLE) && !cfg_we;
    assign accept_in = s_valid && s_ready;
    assign store_px = accept_in && !s_mode &&
                      (in_row_reg < h_eff) && ({1'b0, in_col_reg} < w_eff);
    assign out_fire = m_valid && m_ready;

    // line memory: one write and one read a cycle
    always_ff @(posedge aclk) begin
        if (store_px)
            mem[ADDR_W'(mod5(in_row_reg) * MAX_WIDTH + in_col_reg)] <=
                {s_blue_in, s_green_in, s_red_in};
        rd_reg <= mem[ADDR_W'(slot * MAX_WIDTH + tb_c)];
    end

    logic signed [6:0] kc;
    assign kc = kcoef(fsel_reg, 3'(3'd4 - pi_reg), 3'(3'd4 - pj_reg));

    // scaling and clamp
    function automatic logic [7:0] scl(input logic signed [17:0] s,
                                       input logic [2:0] f);
        logic [16:0] q;
        logic [16:0] d9;
        begin
            q = s[16:0];
            d9 = 17'((34'(q) * 34'd14564) >> 17);
            if (f == K_BOX) q = d9;
            else if (f == K_GAUSS3) q = q >> 4;
            else if (f == K_GAUSS5) q = q >> 8;
            if (s <= 0) return 8'd0;
            return (q > 17'd255) ? 8'd255 : q[7:0];
        end
    endfunction

    logic last_px;
    assign last_px = (out_row_reg == h_eff - 1'b1) &&
                     ({1'b0, out_col_reg} == w_eff - 1'b1);

    // result step and frame restart
    logic out_step, restart;
    assign out_step = (state_reg == ST_OUT) && (!m_valid || out_fire);
    assign restart  = (cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT)) ||
                      (out_step && last_px);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept_in) state_next = ST_CHK;
            ST_CHK:  state_next = more ? ST_TAP : ST_IDLE;
            ST_TAP:  if (ti_reg == 3'd4 && tj_reg == 3'd4) state_next = ST_LAST;
            ST_LAST: state_next = ST_OUT;
            ST_OUT:  if (!m_valid || out_fire) state_next = ST_CHK;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fsel_reg    <= K_IDENT;
            wreg_reg    <= 11'd1024;
            hreg_reg    <= 13'd1;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            m_valid     <= 1'b0;
            m_run_last  <= 1'b0;
            pv_reg      <= 1'b0;
            pend_reg    <= 1'b0;
            nres_reg    <= '0;
        end else begin
            state_reg <= state_next;
            // offer a scaled result once its last flag is known
            if (state_reg == ST_CHK && pend_reg) m_valid <= 1'b1;
            else if (out_fire) m_valid <= 1'b0;
            // configuration
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_FILTER: fsel_reg <= cfg_data[2:0];
                    REG_WIDTH:  wreg_reg <= cfg_data[10:0];
                    REG_HEIGHT: hreg_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept_in) begin
                flush_reg <= s_mode;
                nres_reg  <= '0;
            end
            // position counters
            if (restart) begin
                in_col_reg <= '0; in_row_reg <= '0;
                out_col_reg <= '0; out_row_reg <= '0;
            end else begin
                if (store_px) begin
                    if ({1'b0, in_col_reg} + 1'b1 >= w_eff) begin
                        in_col_reg <= '0;
                        in_row_reg <= in_row_reg + 1'b1;
                    end else begin
                        in_col_reg <= in_col_reg + 1'b1;
                    end
                end
                if (out_step) begin
                    if ({1'b0, out_col_reg} + 1'b1 >= w_eff) begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + 1'b1;
                    end else begin
                        out_col_reg <= out_col_reg + 1'b1;
                    end
                end
            end
            // window sweep
            if (state_reg == ST_CHK) begin
                ti_reg <= '0; tj_reg <= '0; pv_reg <= 1'b0;
                for (int c = 0; c < 3; c++) acc_reg[c] <= '0;
                // last result of this item goes out flagged
                if (pend_reg) begin
                    m_run_last <= !more;
                    pend_reg   <= 1'b0;
                end
            end
            if (state_reg == ST_TAP) begin
                pi_reg <= ti_reg; pj_reg <= tj_reg; pv_reg <= 1'b1;
                if (tj_reg == 3'd4) begin
                    tj_reg <= '0; ti_reg <= ti_reg + 1'b1;
                end else begin
                    tj_reg <= tj_reg + 1'b1;
                end
            end
            if ((state_reg == ST_TAP || state_reg == ST_LAST) && pv_reg) begin
                for (int c = 0; c < 3; c++)
                    acc_reg[c] <= acc_reg[c] +
                        18'(kc) * 18'($signed({1'b0, rd_reg[8*c +: 8]}));
            end
            if (state_reg == ST_LAST) pv_reg <= 1'b0;
            // result hand-over
            if (out_step) begin
                for (int c = 0; c < 3; c++) res_reg[c] <= scl(acc_reg[c], fsel_reg);
                fe_reg   <= last_px;
                pend_reg <= 1'b1;
                nres_reg <= nres_reg + 1'b1;
            end
        end
    end

    assign m_red_out   = res_reg[0];
    assign m_green_out = res_reg[1];
    assign m_blue_out  = res_reg[2];
    assign m_frame_end = fe_reg;

`ifndef ASSERT_OFF
    // results never outrun received rows
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_row_reg <= in_row_reg)) else $error("output ahead of input");
    // no item taken while a sweep runs
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("accept while busy");
    // sweep stays in window bounds
    a_tap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TAP) |-> (ti_reg <= 3'd4 && tj_reg <= 3'd4))
        else $error("tap index out of range");
`endif

endmodule

>>> test/image_conv5x5_filter_checker.sv
`timescale 1ns / 100ps

module image_conv5x5_filter_checker
    import ic5_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_red_in,
    input  logic [7:0]  s_green_in,
    input  logic [7:0]  s_blue_in,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_red_out,
    input  logic [7:0]  m_green_out,
    input  logic [7:0]  m_blue_out,
    input  logic        m_run_last,
    input  logic        m_frame_end,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    output int          fail_count,
    output int          pending_count,
    output int          pixels_seen,
    output int          filtered_seen
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       run_last;
        logic       frame_end;
    } filtered_px_t;

    // kernels by row, 25 taps each
    localparam int KERN [8][25] = '{
        '{0,0,0,0,0, 0,0,0,0,0, 0,0,1,0,0, 0,0,0,0,0, 0,0,0,0,0},
        '{0,0,0,0,0, 0,1,0,-1,0, 0,0,0,0,0, 0,-1,0,1,0, 0,0,0,0,0},
        '{0,0,0,0,0, 0,0,1,0,0, 0,1,-4,1,0, 0,0,1,0,0, 0,0,0,0,0},
        '{0,0,0,0,0, 0,-1,-1,-1,0, 0,-1,8,-1,0, 0,-1,-1,-1,0, 0,0,0,0,0},
        '{0,0,0,0,0, 0,0,-1,0,0, 0,-1,5,-1,0, 0,0,-1,0,0, 0,0,0,0,0},
        '{0,0,0,0,0, 0,1,1,1,0, 0,1,1,1,0, 0,1,1,1,0, 0,0,0,0,0},
        '{0,0,0,0,0, 0,1,2,1,0, 0,2,4,2,0, 0,1,2,1,0, 0,0,0,0,0},
        '{1,4,6,4,1, 4,16,24,16,4, 6,24,36,24,6, 4,16,24,16,4, 1,4,6,4,1}
    };

    pix_t         line_mem [NROWS*MAX_WIDTH];
    int           rx_col, rx_row, tx_col, tx_row;
    logic [2:0]   kernel_sel;
    logic [10:0]  width_reg;
    logic [12:0]  height_reg;
    filtered_px_t filtered_q [$];

    function automatic int frame_w();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int frame_h();
        if (height_reg == 0) return 1;
        if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
        return height_reg;
    endfunction

    function automatic bit window_complete(int w, int h);
        int a;
        int b;
        a = (tx_row + 2 > h - 1) ? h - 1 : tx_row + 2;
        b = (tx_col + 2 > w - 1) ? w - 1 : tx_col + 2;
        return a < rx_row || (a == rx_row && b < rx_col);
    endfunction

    function automatic logic [7:0] scale_sat(int s, logic [2:0] f);
        int q;
        if (s <= 0) return 8'd0;
        q = s;
        if (f == K_BOX) q = q / 9;
        else if (f == K_GAUSS3) q = q >> 4;
        else if (f == K_GAUSS5) q = q >> 8;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // convolve the window at the next output position and advance
    task automatic convolve_next(int w, int h);
        int sum [3];
        int a;
        int b;
        int k;
        pix_t p;
        filtered_px_t res;
        sum = '{0, 0, 0};
        for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 5; j++) begin
                a = tx_row - 2 + i;
                b = tx_col - 2 + j;
                if (a < 0) a = 0;
                if (a > h - 1) a = h - 1;
                if (b < 0) b = 0;
                if (b > w - 1) b = w - 1;
                p = line_mem[(a % NROWS)*MAX_WIDTH + b];
                k = KERN[kernel_sel][(4 - i)*5 + (4 - j)];
                for (int c = 0; c < 3; c++)
                    sum[c] += k * int'(p[8*c +: 8]);
            end
        end
        res.red       = scale_sat(sum[0], kernel_sel);
        res.green     = scale_sat(sum[1], kernel_sel);
        res.blue      = scale_sat(sum[2], kernel_sel);
        res.run_last  = 1'b0;
        res.frame_end = (tx_row == h - 1) && (tx_col == w - 1);
        tx_col++;
        if (tx_col >= w) begin
            tx_col = 0;
            tx_row++;
        end
        if (res.frame_end) begin
            rx_col = 0; rx_row = 0; tx_col = 0; tx_row = 0;
        end
        filtered_q.push_back(res);
    endtask

    task automatic predict_item(logic mode, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int w;
        int h;
        int n;
        w = frame_w();
        h = frame_h();
        n = 0;
        if (!mode) begin
            if (rx_row < h && rx_col < w) begin
                line_mem[(rx_row % NROWS)*MAX_WIDTH + rx_col] = {b, g, r};
                rx_col++;
                if (rx_col >= w) begin
                    rx_col = 0;
                    rx_row++;
                end
            end
            while (n < 3 && tx_row + 2 < h && window_complete(w, h)) begin
                convolve_next(w, h);
                n++;
            end
        end else if (tx_row < h && window_complete(w, h)) begin
            convolve_next(w, h);
            n = 1;
        end
        if (n > 0) filtered_q[$].run_last = 1'b1;
    endtask

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // prediction first, then comparison, all on pre-edge values
    always @(posedge aclk) begin
        filtered_px_t want;
        if (!aresetn) begin
            rx_col = 0; rx_row = 0; tx_col = 0; tx_row = 0;
            kernel_sel = K_IDENT;
            width_reg  = 11'd1024;
            height_reg = 13'd1;
            filtered_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_FILTER: kernel_sel = cfg_data[2:0];
                    REG_WIDTH: begin
                        width_reg = cfg_data[10:0];
                        rx_col = 0; rx_row = 0; tx_col = 0; tx_row = 0;
                    end
                    REG_HEIGHT: begin
                        height_reg = cfg_data;
                        rx_col = 0; rx_row = 0; tx_col = 0; tx_row = 0;
                    end
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predict_item(s_mode, s_red_in, s_green_in, s_blue_in);
                pixels_seen++;
            end
            if (m_valid && m_ready) begin
                filtered_seen++;
                if (filtered_q.size() == 0) begin
                    $error("unexpected result item");
                    fail_count++;
                end else begin
                    want = filtered_q.pop_front();
                    check_field("red_out", want.red, m_red_out);
                    check_field("green_out", want.green, m_green_out);
                    check_field("blue_out", want.blue, m_blue_out);
                    check_field("run_last", want.run_last, m_run_last);
                    check_field("frame_end", want.frame_end, m_frame_end);
                end
            end
        end
        pending_count = filtered_q.size();
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ic5_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_mode;
    logic [7:0]  s_red_in;
    logic [7:0]  s_green_in;
    logic [7:0]  s_blue_in;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_red_out;
    logic [7:0]  m_green_out;
    logic [7:0]  m_blue_out;
    logic        m_run_last;
    logic        m_frame_end;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;

    int fail_count;
    int pending_count;
    int pixels_seen;
    int filtered_seen;
    int items_sent;
    int cycle_count;
    int frames_run;

    image_conv5x5_filter_core uut (.*);

    image_conv5x5_filter_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // idle rates: receiver slow, then sender slow, then free running
    function automatic int sender_idle_pct();
        if (items_sent < 160) return 31;
        if (items_sent < 320) return 65;
        return 0;
    endfunction

    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if (items_sent < 160) m_ready <= ($urandom_range(99) >= 65);
        else if (items_sent < 320) m_ready <= ($urandom_range(99) >= 31);
        else m_ready <= 1'b1;
    end

    // run watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic send_item(logic mode, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct()) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_mode     <= mode;
        s_red_in   <= r;
        s_green_in <= g;
        s_blue_in  <= b;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_pixel();
        send_item(MODE_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_flush();
        send_item(MODE_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // hold off until every expected result is out and the block is quiet
    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_frame(logic [2:0] f, logic [12:0] w, logic [12:0] h);
        drain();
        write_reg(REG_FILTER, 13'(f));
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        @(negedge aclk);
    endtask

    // one frame of random pixels with stray flushes, then the draining flushes
    task automatic run_frame(int w, int h);
        for (int i = 0; i < w*h; i++) begin
            if ($urandom_range(9) == 0) send_flush();
            send_pixel();
        end
        if ($urandom_range(5) == 0)
            repeat ($urandom_range(1, 3)) send_pixel();
        repeat (2*w + 3) send_flush();
        frames_run++;
    endtask

    initial begin
        int w;
        int h;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_mode    = MODE_PIXEL;
        s_red_in  = 8'd0;
        s_green_in = 8'd0;
        s_blue_in = 8'd0;
        cfg_we    = 1'b0;
        cfg_index = REG_FILTER;
        cfg_data  = 13'd0;
        items_sent = 0;
        frames_run = 0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // flush with nothing ready, under the reset geometry
        send_flush();
        // full width, single row: three pixels then a flush
        set_frame(K_SHARP, 13'd2047, 13'd0);
        send_item(MODE_PIXEL, 8'hff, 8'h00, 8'haa);
        send_item(MODE_PIXEL, 8'h00, 8'hff, 8'h55);
        send_item(MODE_PIXEL, 8'hff, 8'hff, 8'hff);
        send_flush();
        // tall frame, then aborted by a geometry write
        set_frame(K_GAUSS5, 13'd1024, 13'd8191);
        send_item(MODE_PIXEL, 8'h00, 8'h00, 8'h00);
        // zero width, 3 rows: extremes through the edge kernel
        set_frame(K_EDGE3, 13'd0, 13'd3);
        send_item(MODE_PIXEL, 8'hff, 8'hff, 8'hff);
        send_item(MODE_PIXEL, 8'h00, 8'h00, 8'h00);
        send_item(MODE_PIXEL, 8'hff, 8'h00, 8'hff);
        send_pixel();
        repeat (2) send_flush();
        // ignored config index
        drain();
        write_reg(REG_UNUSED, 13'h1fff);
        // 3x3 with an extra pixel after the frame is full
        set_frame(K_IDENT, 13'd3, 13'd3);
        for (int i = 0; i < 9; i++)
            send_item(MODE_PIXEL, (i % 2) ? 8'hff : 8'h00, 8'(i * 29), 8'h80);
        send_pixel();
        repeat (7) send_flush();

        // random frames through all kernels
        while (items_sent < 470) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            h = ($urandom_range(9) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
            set_frame(3'($urandom), 13'(w), 13'(h));
            run_frame(w, h);
        end

        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        $display("run covered %0d input items over %0d random frames, %0d results checked",
                 pixels_seen, frames_run, filtered_seen);
        if (fail_count == 0 && pending_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/ic5_pkg.sv
rtl/core/image_conv5x5_filter_core.sv
test/image_conv5x5_filter_checker.sv
test/testbench.sv
